// File: hdl/signed_decimal_parser_saturating_unit_defines.svh
// assertion macros used by the parser top level
`ifndef SIGNED_DECIMAL_PARSER_SATURATING_UNIT_DEFINES_SVH
`define SIGNED_DECIMAL_PARSER_SATURATING_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/sdp_pkg.sv
package sdp_pkg;

  // width of the signed value that saturates, and of the number field
  localparam int VALUE_BITS = 32;
  localparam int NUM_W      = 32;
  localparam int MAG_W      = VALUE_BITS - 1;
  // magnitude times ten plus a digit
  localparam int SUM_W      = MAG_W + 4;
  localparam int CHAR_W     = 8;

  localparam logic [MAG_W-1:0] MAG_CEIL = {MAG_W{1'b1}};

  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGNED,
    PH_DIGITS,
    PH_TRAIL,
    PH_BAD
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } parse_state_t;

  typedef struct packed {
    logic             valid_res;
    logic [NUM_W-1:0] number;
  } result_t;

endpackage

// File: hdl/sdp_step.sv
module sdp_step
  import sdp_pkg::*;
(
  input  parse_state_t      cur,
  input  logic [CHAR_W-1:0] character,
  input  logic              has_char,
  output parse_state_t      nxt
);

  logic             space_c;
  logic             digit_c;
  logic             sign_c;
  logic [3:0]       digit;
  logic [SUM_W-1:0] sum;
  logic [MAG_W-1:0] mag_add;

  assign space_c = (character == CHAR_TAB) || (character == CHAR_LF) ||
                   (character == CHAR_FF) || (character == CHAR_CR) ||
                   (character == CHAR_SPACE);
  assign digit_c = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
  assign sign_c  = (character == CHAR_PLUS) || (character == CHAR_MINUS);
  assign digit   = 4'(character - CHAR_ZERO);

  // mag * 10 + digit as two shifts and adds, then clamp to the ceiling
  assign sum = {1'b0, cur.mag, 3'b000} + {3'b000, cur.mag, 1'b0} + SUM_W'(digit);
  assign mag_add = (sum > SUM_W'(MAG_CEIL)) ? MAG_CEIL : sum[MAG_W-1:0];

  always_comb begin
    nxt = cur;
    if (has_char) begin
      case (cur.phase)
        PH_LEAD: begin
          if (space_c) begin
            nxt.phase = PH_LEAD;
          end else if (sign_c) begin
            nxt.neg   = (character == CHAR_MINUS);
            nxt.phase = PH_SIGNED;
          end else if (digit_c) begin
            nxt.mag   = mag_add;
            nxt.phase = PH_DIGITS;
          end else begin
            nxt.phase = PH_BAD;
          end
        end
        PH_SIGNED: begin
          if (digit_c) begin
            nxt.mag   = mag_add;
            nxt.phase = PH_DIGITS;
          end else begin
            nxt.phase = PH_BAD;
          end
        end
        PH_DIGITS: begin
          if (digit_c) begin
            nxt.mag = mag_add;
          end else if (space_c) begin
            nxt.phase = PH_TRAIL;
          end else begin
            nxt.phase = PH_BAD;
          end
        end
        PH_TRAIL: begin
          if (!space_c) begin
            nxt.phase = PH_BAD;
          end
        end
        default: begin
          nxt.phase = PH_BAD;
        end
      endcase
    end
  end

endmodule

// File: hdl/sdp_out_skid.sv
module sdp_out_skid
  import sdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_v;
  logic    skid_v;
  result_t main_d;
  result_t skid_d;
  logic    pop;

  assign in_ready  = !skid_v;
  assign out_valid = main_v;
  assign out_data  = main_d;
  assign pop       = main_v && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (pop) begin
      if (skid_v) begin
        skid_v <= 1'b0;
      end else if (!push) begin
        main_v <= 1'b0;
      end
    end else if (push && main_v) begin
      skid_v <= 1'b1;
    end else if (push) begin
      main_v <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop && skid_v) begin
      main_d <= skid_d;
    end else if (push && (pop || !main_v)) begin
      main_d <= push_data;
    end else if (push) begin
      skid_d <= push_data;
    end
  end

endmodule

// File: hdl/signed_decimal_parser_saturating_unit.sv
// signed decimal parser with saturation
// slave stream: one text byte per beat; s_axis_tuser set means the byte belongs
//   to the text, clear adds nothing; s_axis_tlast closes the text
// master stream: one result beat per text, issued for the tlast beat;
//   m_axis_tuser is 1 when the text is a valid signed decimal, and m_axis_tdata
//   holds the value (magnitude clamped at 2^31-1, sign applied), 0 when invalid
// leading and trailing tab, lf, ff, cr and space are skipped; one optional
//   sign, then at least one digit and nothing else
// throughput: one beat per cycle on the slave side, sustained while the output
//   registers have room for a last beat's result, set by the combinational
//   byte update (ten-times-plus-digit add and clamp); a tlast beat goes from
//   the input register to the output registers before its result reaches the port
// stall: the result sits in an output register backed by a skid register;
//   parsing continues on non-last beats, and a last beat waits in the input
//   register only when both output registers are full
// reset: synchronous, active high; drops any beat in flight and any partial
//   text, and the parser starts a fresh text
`include "signed_decimal_parser_saturating_unit_defines.svh"

module signed_decimal_parser_saturating_unit
  import sdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] character
  input  logic              s_axis_tuser,   // [0] has_char
  input  logic              s_axis_tlast,   // is_last
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [NUM_W-1:0]  m_axis_tdata,   // [31:0] number
  output logic              m_axis_tuser    // [0] valid_res
);

  // input register
  logic              iv;
  logic [CHAR_W-1:0] ichar;
  logic              ihas;
  logic              ilast;

  // parse state carried across the bytes of one text
  parse_state_t st;
  parse_state_t st_next;
  logic         st_clean;

  logic              advance;
  logic              out_ready;
  logic              ok;
  logic [VALUE_BITS-1:0] val_mag;
  logic [VALUE_BITS-1:0] val;
  result_t           res;
  result_t           out_data;

  // a non-last byte always moves on; a last one needs room for its result
  assign advance       = iv && (!ilast || out_ready);
  assign s_axis_tready = !iv || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (s_axis_tready) begin
      iv <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      ichar <= s_axis_tdata;
      ihas  <= s_axis_tuser;
      ilast <= s_axis_tlast;
    end
  end

  sdp_step u_step (
    .cur       (st),
    .character (ichar),
    .has_char  (ihas),
    .nxt       (st_next)
  );

  // state returns to the start of a text after every last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PH_LEAD;
      st.neg   <= 1'b0;
      st.mag   <= '0;
    end else if (advance && ilast) begin
      st.phase <= PH_LEAD;
      st.neg   <= 1'b0;
      st.mag   <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  assign st_clean = (st.phase == PH_LEAD) && (st.mag == '0) && !st.neg;

  // result from the state after the last byte
  assign ok      = (st_next.phase == PH_DIGITS) || (st_next.phase == PH_TRAIL);
  assign val_mag = {1'b0, st_next.mag};
  assign val     = st_next.neg ? ('0 - val_mag) : val_mag;

  always_comb begin
    res.valid_res = ok;
    res.number    = ok ? NUM_W'($signed(val)) : '0;
  end

  sdp_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && ilast),
    .push_data (res),
    .in_ready  (out_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = out_data.number;
  assign m_axis_tuser = out_data.valid_res;

  // skid register only fills behind a full output register
  `SDP_ASSERT_NOW(a_skid_behind_main, !out_ready, m_axis_tvalid, "skid full with output empty")
  // a closed text leaves a clean state for the next one
  `SDP_ASSERT_NEXT(a_reset_after_last, advance && ilast, st_clean, "state not cleared after tlast")
  // nothing accumulates before the first sign or digit
  `SDP_ASSERT_NOW(a_lead_clean, st.phase == PH_LEAD, (st.mag == '0) && !st.neg, "leading phase holds a value")
  // rejected texts report zero
  `SDP_ASSERT_NOW(a_invalid_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "invalid result with nonzero number")

endmodule
